// ===== design/lsap_pkg.sv =====
// Shared types, constants and line-state codes of the line sensor position core.
package lsap_pkg;

  // Sensor array geometry and field widths.
  localparam int SENSOR_COUNT = 7;
  localparam int WEIGHT_W     = 7;
  localparam int COUNT_W      = 3;
  localparam int STATE_W      = 3;
  localparam int SUM_W        = 10;
  localparam int MAG_W        = 9;
  localparam int CFG_ADDR_W   = 3;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 32;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH  = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_BLACK_IS_HIGH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_0      = 3'd1;

  // Line state codes.
  localparam logic [STATE_W-1:0] ST_ON_LINE     = 3'd0;
  localparam logic [STATE_W-1:0] ST_LEFT        = 3'd1;
  localparam logic [STATE_W-1:0] ST_RIGHT       = 3'd2;
  localparam logic [STATE_W-1:0] ST_SHARP_LEFT  = 3'd3;
  localparam logic [STATE_W-1:0] ST_SHARP_RIGHT = 3'd4;
  localparam logic [STATE_W-1:0] ST_NO_LINE     = 3'd5;
  localparam logic [STATE_W-1:0] ST_ALL_LINE    = 3'd6;

  // Position limits for patterns outside the table.
  localparam logic signed [WEIGHT_W-1:0] POS_LEFT_LIMIT  = -7'sd15;
  localparam logic signed [WEIGHT_W-1:0] POS_RIGHT_LIMIT = 7'sd15;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  // Configuration as seen by the front.
  typedef struct packed {
    logic                          black_is_high;
    weight_t [SENSOR_COUNT-1:0]    weight;
  } lsap_cfg_t;

  // One classified sample waiting for the divide.
  typedef struct packed {
    logic [SENSOR_COUNT-1:0]  raw;
    logic [SENSOR_COUNT-1:0]  act;
    logic [COUNT_W-1:0]       count;
    logic signed [SUM_W-1:0]  sum;
    logic                     table_hit;
    logic [STATE_W-1:0]       table_state;
  } lsap_entry_t;

  // One finished result.
  typedef struct packed {
    logic                     detected;
    logic [STATE_W-1:0]       state;
    weight_t                  position;
    logic [COUNT_W-1:0]       count;
    logic [SENSOR_COUNT-1:0]  act;
    logic [SENSOR_COUNT-1:0]  raw;
  } lsap_result_t;

  // Reset value of a sensor weight.
  function automatic weight_t weight_reset(input int idx);
    weight_t w;
    w = WEIGHT_W'(idx * 10 - 30);
    return w;
  endfunction

endpackage

// ===== design/lsap_front.sv =====
// Front part: polarity correction, count, weight sum and table classification.
module lsap_front
  import lsap_pkg::*;
(
  input  lsap_cfg_t                cfg,
  input  logic [SENSOR_COUNT-1:0]  raw,
  output lsap_entry_t              entry
);

  logic [SENSOR_COUNT-1:0]  act;
  logic [COUNT_W-1:0]       cnt;
  logic signed [SUM_W-1:0]  sum;
  logic                     hit;
  logic [STATE_W-1:0]       tstate;

  // Active bits, their count and the sum of their weights.
  always_comb begin
    act = cfg.black_is_high ? raw : ~raw;
    cnt = '0;
    sum = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      cnt = cnt + COUNT_W'(act[i]);
      if (act[i]) begin
        sum = sum + SUM_W'($signed(cfg.weight[i]));
      end
    end
  end

  // Fixed pattern table; a miss is settled by the position in the back.
  always_comb begin
    hit    = 1'b1;
    tstate = ST_ON_LINE;
    if (cnt == '0) begin
      tstate = ST_NO_LINE;
    end else if (act == {SENSOR_COUNT{1'b1}}) begin
      tstate = ST_ALL_LINE;
    end else begin
      unique case (act) inside
        7'b0001000, 7'b0011000, 7'b0001100, 7'b0011100: begin
          tstate = ST_ON_LINE;
        end
        7'b0000001, 7'b0000011, 7'b0000111, 7'b0110000, 7'b0111000: begin
          tstate = ST_LEFT;
        end
        7'b1000000, 7'b1100000, 7'b1110000, 7'b0000110, 7'b0001110: begin
          tstate = ST_RIGHT;
        end
        7'b0000010, 7'b0000100: begin
          tstate = ST_SHARP_LEFT;
        end
        7'b0100000, 7'b0010000: begin
          tstate = ST_SHARP_RIGHT;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  assign entry.raw         = raw;
  assign entry.act         = act;
  assign entry.count       = cnt;
  assign entry.sum         = sum;
  assign entry.table_hit   = hit;
  assign entry.table_state = tstate;

endmodule

// ===== design/lsap_queue.sv =====
// Short queue of classified samples between the front and the back.
module lsap_queue
  import lsap_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lsap_entry_t  push_data,
  output logic         full,
  input  logic         pop,
  output lsap_entry_t  pop_data,
  output logic         not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  lsap_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  fill_r;

  assign full      = (fill_r == CNT_W'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/lsap_back.sv =====
// Back part: serial mean divide, held position, final state and output register.
module lsap_back
  import lsap_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lsap_entry_t   q_data,
  output logic          q_pop,
  output logic          res_valid,
  input  logic          res_ready,
  output lsap_result_t  res
);

  localparam int STEP_W = $clog2(MAG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } back_state_t;

  back_state_t         state_r;
  lsap_entry_t         entry_r;
  logic                neg_r;
  logic [MAG_W-1:0]    dvd_r;
  logic [COUNT_W-1:0]  rem_r;
  logic [STEP_W-1:0]   step_r;
  weight_t             held_r;
  lsap_result_t        res_r;

  logic                 sum_neg;
  logic [SUM_W-1:0]     sum_abs;
  logic [COUNT_W:0]     trial;
  logic                 ge;
  logic [COUNT_W:0]     trial_sub;
  logic [MAG_W-1:0]     quo;
  weight_t              pos;
  logic [STATE_W-1:0]   fin_state;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Magnitude of the incoming weight sum.
  assign sum_neg = q_data.sum[SUM_W-1];
  assign sum_abs = sum_neg ? SUM_W'(-q_data.sum) : q_data.sum;

  // One restoring divide step: remainder stays below the count.
  assign trial     = {rem_r, dvd_r[MAG_W-1]};
  assign ge        = (trial >= {1'b0, entry_r.count});
  assign trial_sub = trial - {1'b0, entry_r.count};
  assign quo       = {dvd_r[MAG_W-2:0], ge};
  assign pos       = neg_r ? WEIGHT_W'(-quo[WEIGHT_W-1:0]) : quo[WEIGHT_W-1:0];

  // Patterns outside the table are classed by the position.
  always_comb begin
    if (entry_r.table_hit) begin
      fin_state = entry_r.table_state;
    end else if (pos < POS_LEFT_LIMIT) begin
      fin_state = ST_LEFT;
    end else if (pos > POS_RIGHT_LIMIT) begin
      fin_state = ST_RIGHT;
    end else begin
      fin_state = ST_ON_LINE;
    end
  end

  // Divider datapath and result register.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          entry_r <= q_data;
          neg_r   <= sum_neg;
          dvd_r   <= sum_abs[MAG_W-1:0];
          rem_r   <= '0;
          step_r  <= '0;
          res_r.raw      <= q_data.raw;
          res_r.act      <= q_data.act;
          res_r.count    <= q_data.count;
          res_r.detected <= (q_data.count != '0);
          res_r.position <= held_r;
          res_r.state    <= q_data.table_state;
        end
      end
      S_DIV: begin
        dvd_r  <= quo;
        rem_r  <= ge ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          res_r.position <= pos;
          res_r.state    <= fin_state;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and held position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= (q_data.count == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (step_r == LAST_STEP) begin
            held_r  <= pos;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A divide never starts with a zero count.
  a_div_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (entry_r.count != '0))
    else $error("divide running with zero count");

  // The held position moves only at the end of a divide.
  a_held_only_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> $past(state_r == S_DIV && step_r == LAST_STEP))
    else $error("held position changed outside a divide");

  // A result without detection carries the no-line state.
  a_no_line_state: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_r.detected) |-> (res_r.state == ST_NO_LINE))
    else $error("no-line result with wrong state");

  // Every pop starts a sample: the back part then divides or holds a result.
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DIV || state_r == S_DONE))
    else $error("pop did not start a sample");

endmodule

// ===== design/line_sensor_array_position_core.sv =====
// Top level of the line sensor position core: configuration registers and stream wiring.
//
//  Channel  | Direction | Content
//  ---------+-----------+-----------------------------------------------------------
//  in_*     | slave     | tdata[6:0] raw_levels
//  out_*    | master    | tdata raw_bits, active_bits, active_count, line_position,
//           |           |       line_state, line_detected (low bit up)
//  cfg_*    | write     | cfg_addr 0 black_is_high, 1..7 weight_0..weight_6
//
//  A sample with active sensors enters the queue, leaves it when the back part
//  is idle, runs the one-bit-a-cycle restoring divide and waits in the output
//  register for the result transfer; one with no active sensor skips the divide.
//  The front and queue take a new sample each cycle until the queue is full, so
//  input stalls only when the back part is behind. Reset is synchronous, active
//  low, and clears the queue, the sequencer, the held position and the registers.
module line_sensor_array_position_core
  import lsap_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input samples.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [6:0] raw_levels, [7] zero
  // Results.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [6:0] raw_bits, [13:7] active_bits,
                                             // [16:14] active_count,
                                             // [23:17] line_position,
                                             // [26:24] line_state,
                                             // [27] line_detected, [31:28] zero
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [WEIGHT_W-1:0]    cfg_wdata
);

  lsap_cfg_t     cfg_r;
  lsap_entry_t   front_entry, q_entry;
  logic          q_full, q_valid, q_pop;
  lsap_result_t  res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_is_high <= 1'b1;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        cfg_r.weight[i] <= weight_reset(i);
      end
    end else if (cfg_we) begin
      if (cfg_addr == REG_BLACK_IS_HIGH) begin
        cfg_r.black_is_high <= cfg_wdata[0];
      end else begin
        cfg_r.weight[cfg_addr - REG_WEIGHT_0] <= cfg_wdata;
      end
    end
  end

  lsap_front u_front (
    .cfg   (cfg_r),
    .raw   (in_tdata[SENSOR_COUNT-1:0]),
    .entry (front_entry)
  );

  assign in_tready = !q_full;

  lsap_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .not_empty (q_valid)
  );

  lsap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_entry),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Result packing, highest field first.
  assign out_tdata = {4'b0000, res.detected, res.state, res.position, res.count,
                      res.act, res.raw};

endmodule
